>>> hdl/slrb_pkg.sv
// Shared types, opcodes, character constants and the byte sanitizer for the line ring buffer.
package slrb_pkg;

    localparam int unsigned LEN_W = 11;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } state_t;

    // printable, CR and LF pass; anything else becomes '?'
    function automatic logic [7:0] sanitize(input logic [7:0] b);
        logic keep;
        keep = ((b >= 8'h20) && (b <= 8'h7E)) || (b == CH_CR) || (b == CH_LF);
        return keep ? b : CH_QMARK;
    endfunction

endpackage

>>> hdl/slrb_store.sv
// Byte store: one write port, one registered read port, zero-fill pass after reset.
module slrb_store import slrb_pkg::*; #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata,
    output logic          init_done
);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          clr_done_reg, clr_done_next;
    logic [7:0]    rdata_reg;

    always_comb begin
        clr_addr_next = clr_addr_reg;
        clr_done_next = clr_done_reg;
        if (!clr_done_reg) begin
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_done_next = 1'b1;
            end else begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_done_reg <= 1'b0;
        end else begin
            clr_addr_reg <= clr_addr_next;
            clr_done_reg <= clr_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!clr_done_reg) begin
            mem[clr_addr_reg] <= CH_NUL;
        end else if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata     = rdata_reg;
    assign init_done = clr_done_reg;

endmodule

>>> hdl/sanitizing_line_ring_buffer.sv
// Top level: sequencer, pointers, LF compare and result register of the line ring buffer.
// Write and unused opcode: result registered at the accept edge.
// Read: registered memory read, then clear of the entry and result load.
// Check: one store entry compared per cycle through the memory read port.
// Reset: synchronous, active low; a zero-fill pass follows, with s_ready low.
// Back-to-back transfers need the result register to be empty or drained in the same cycle.
module sanitizing_line_ring_buffer import slrb_pkg::*; #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_func,
    input  logic [7:0]       s_data_byte,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_read_byte,
    output logic [LEN_W-1:0] m_cmd_length
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = (CW + 1 > LEN_W) ? CW + 1 : LEN_W;

    state_t           state_reg, state_next;
    logic [AW-1:0]    wptr_reg, wptr_next;
    logic [AW-1:0]    rptr_reg, rptr_next;
    logic [AW-1:0]    scan_addr_reg, scan_addr_next;
    logic [CW-1:0]    issue_cnt_reg, issue_cnt_next;
    logic [CW-1:0]    rd_cnt_reg, rd_cnt_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic [LEN_W-1:0] out_len_reg, out_len_next;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [7:0]       mem_rdata;
    logic             init_done;
    logic             s_xfer;
    logic             out_free;
    logic             lf_hit;
    logic [SW-1:0]    len_sum;

    slrb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .we        (mem_we),
        .waddr     (mem_waddr),
        .wdata     (mem_wdata),
        .raddr     (mem_raddr),
        .rdata     (mem_rdata),
        .init_done (init_done)
    );

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = init_done && (state_reg == ST_IDLE) && out_free;
    assign s_xfer    = s_valid && s_ready;
    assign mem_raddr = (state_reg == ST_SCAN) ? scan_addr_reg : rptr_reg;
    assign lf_hit    = (mem_rdata == CH_LF);
    assign len_sum   = SW'(rd_cnt_reg) + SW'(1);

    always_comb begin
        state_next     = state_reg;
        wptr_next      = wptr_reg;
        rptr_next      = rptr_reg;
        scan_addr_next = scan_addr_reg;
        issue_cnt_next = issue_cnt_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_vld_next    = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        out_byte_next  = out_byte_reg;
        out_len_next   = out_len_reg;
        mem_we         = 1'b0;
        mem_waddr      = wptr_reg;
        mem_wdata      = sanitize(s_data_byte);

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    case (s_func)
                        OP_WRITE: begin
                            mem_we        = 1'b1;
                            wptr_next     = ptr_inc(wptr_reg);
                            m_valid_next  = 1'b1;
                            out_byte_next = CH_NUL;
                            out_len_next  = '0;
                        end
                        OP_READ: begin
                            state_next = ST_READ;
                        end
                        OP_CHECK: begin
                            state_next     = ST_SCAN;
                            scan_addr_next = rptr_reg;
                            issue_cnt_next = '0;
                        end
                        default: begin
                            m_valid_next  = 1'b1;
                            out_byte_next = CH_NUL;
                            out_len_next  = '0;
                        end
                    endcase
                end
            end
            ST_READ: begin
                // entry read at the accept edge is now registered; clear it
                mem_we        = 1'b1;
                mem_waddr     = rptr_reg;
                mem_wdata     = CH_NUL;
                rptr_next     = ptr_inc(rptr_reg);
                m_valid_next  = 1'b1;
                out_byte_next = mem_rdata;
                out_len_next  = '0;
                state_next    = ST_IDLE;
            end
            ST_SCAN: begin
                if (issue_cnt_reg < CW'(DEPTH)) begin
                    rd_vld_next    = 1'b1;
                    rd_cnt_next    = issue_cnt_reg;
                    issue_cnt_next = issue_cnt_reg + CW'(1);
                    scan_addr_next = ptr_inc(scan_addr_reg);
                end
                if (rd_vld_reg) begin
                    if (lf_hit) begin
                        m_valid_next  = 1'b1;
                        out_byte_next = CH_NUL;
                        out_len_next  = len_sum[LEN_W-1:0];
                        rd_vld_next   = 1'b0;
                        state_next    = ST_IDLE;
                    end else if (rd_cnt_reg == CW'(DEPTH - 1)) begin
                        m_valid_next  = 1'b1;
                        out_byte_next = CH_NUL;
                        out_len_next  = '0;
                        rd_vld_next   = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wptr_reg    <= '0;
            rptr_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wptr_reg    <= wptr_next;
            rptr_reg    <= rptr_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_addr_reg <= scan_addr_next;
        issue_cnt_reg <= issue_cnt_next;
        rd_cnt_reg    <= rd_cnt_next;
        out_byte_reg  <= out_byte_next;
        out_len_reg   <= out_len_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_read_byte  = out_byte_reg;
    assign m_cmd_length = out_len_reg;

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !s_ready)
        else $error("transfer accepted during zero-fill pass");

    a_read_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> !m_valid_reg)
        else $error("read result would overwrite a pending result");

    a_write_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && (s_func == OP_WRITE)) |=> (m_valid && (m_read_byte == CH_NUL)))
        else $error("write transfer did not yield a result");

    a_scan_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (!m_valid_reg && !s_ready))
        else $error("scan overlaps a pending result or accepts input");

endmodule
